// File: rtl/core/rsf64_pkg.sv
// Shared types, constants and a helper function for the double-precision radix sorter.
// No dependencies.
package rsf64_pkg;
  localparam int MAX_ITEMS_DEF  = 64;
  localparam int DIGIT_BITS_DEF = 8;
  localparam int PASS_COUNT_DEF = 8;
  localparam int WORD_W         = 64;

  typedef struct packed {
    logic load;        // write input item at fill slot
    logic clr_run;     // clear count and overflow flag
    logic cnt_clr;     // clear bucket counter at sweep address
    logic cnt_inc;     // count digit of element read
    logic pfx;         // prefix step at sweep address
    logic scat;        // scatter element read
    logic copy;        // copy scratch back to store
    logic fix_neg;     // fix-up, negatives pass
    logic fix_pos;     // fix-up, non-negatives pass
    logic emit;        // emit element read
    logic rd_req;      // issue a store read at the sweep address (reversed in the negatives pass)
    logic idx_clr;     // clear sweep index
    logic idx_inc;     // advance sweep index
    logic pass_clr;
    logic pass_inc;
    logic wk_clr;      // clear fix-up write pointer
  } rsf64_cmd_t;

  typedef struct packed {
    logic idx_end_elem;   // sweep index reached element count
    logic idx_end_bkt;    // sweep index reached bucket count
    logic pass_end;       // pass counter at the last pass
  } rsf64_sts_t;

  function automatic logic below_zero(input logic [WORD_W-1:0] v);
    below_zero = v[WORD_W-1] && (v[WORD_W-2:0] != '0)
                 && (v[WORD_W-2:0] <= 63'h7FF0000000000000);
  endfunction
endpackage

// File: rtl/core/rsf64_dp.sv
// Datapath of the radix sorter: element and scratch memories, bucket table,
// sweep counters and result registers. Depends on rsf64_pkg.
module rsf64_dp import rsf64_pkg::*; #(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int DIGIT_BITS = DIGIT_BITS_DEF,
  parameter int PASS_COUNT = PASS_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [WORD_W-1:0] value_bits,
  input  rsf64_cmd_t        cmd,
  output rsf64_sts_t        sts,
  output logic              result_valid,
  output logic [WORD_W-1:0] sorted_bits,
  output logic              end_of_run,
  output logic              truncated
);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int NB  = 1 << DIGIT_BITS;
  localparam int IW  = ((CW > DIGIT_BITS) ? CW : DIGIT_BITS) + 1;
  localparam int PW  = (PASS_COUNT > 1) ? $clog2(PASS_COUNT) : 1;

  logic [WORD_W-1:0] elem_mem [MAX_ITEMS];
  logic [WORD_W-1:0] scr_mem  [MAX_ITEMS];
  logic [CW-1:0]     bkt_mem  [NB];

  logic [CW-1:0]     count;
  logic              overflow;
  logic [IW-1:0]     idx;
  logic [PW-1:0]     pass;
  logic [CW-1:0]     wk;

  // pipeline stage after the store read
  logic              rd_v;
  logic [CW-1:0]     rd_idx;
  logic [WORD_W-1:0] rd_data;
  logic              scr_rd_v;
  logic [AW-1:0]     scr_rd_addr;
  logic [WORD_W-1:0] scr_rd_data;

  logic [DIGIT_BITS-1:0] dig;
  logic [CW-1:0]     pfx_total;

  // bucket table: registered read, written back in the cycle after the read
  logic [DIGIT_BITS-1:0] bkt_addr;
  logic [CW-1:0]     bkt_rd;
  logic              bk_v;      // count/scatter update of the element read
  logic              pf_v;      // prefix write of the bucket read
  logic [DIGIT_BITS-1:0] pf_addr;

  // store read address; the negatives pass walks from the top down
  logic [CW-1:0]     rev_idx;
  logic [AW-1:0]     rd_addr;

  // digit of the element read for the current pass
  always_comb begin
    logic [WORD_W-1:0] sh;
    logic [31:0] amt;
    amt = 32'(pass) * 32'(DIGIT_BITS);
    sh  = rd_data >> amt[6:0];
    dig = (amt >= 32'(WORD_W)) ? '0 : sh[DIGIT_BITS-1:0];
  end

  assign bkt_addr = cmd.pfx ? idx[DIGIT_BITS-1:0] : dig;
  assign rev_idx  = count - idx[CW-1:0] - 1'b1;
  assign rd_addr  = cmd.fix_neg ? rev_idx[AW-1:0] : idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load && count < CW'(MAX_ITEMS)) elem_mem[count[AW-1:0]] <= value_bits;
    if (cmd.rd_req) rd_data <= elem_mem[rd_addr];
    scr_rd_addr <= idx[AW-1:0];
    scr_rd_data <= scr_mem[idx[AW-1:0]];
    rd_idx <= idx[CW-1:0];
    bkt_rd <= bkt_mem[bkt_addr];
    pf_addr <= idx[DIGIT_BITS-1:0];
    if (cmd.cnt_clr) bkt_mem[idx[DIGIT_BITS-1:0]] <= '0;
    if (pf_v) bkt_mem[pf_addr] <= pfx_total;
    if (bk_v && (cmd.cnt_inc || cmd.scat)) bkt_mem[dig] <= bkt_rd + 1'b1;
    if (bk_v && cmd.scat) scr_mem[bkt_rd[AW-1:0]] <= rd_data;
    if (scr_rd_v && cmd.copy) elem_mem[scr_rd_addr] <= scr_rd_data;
    if (rd_v && ((cmd.fix_neg && below_zero(rd_data)) ||
                 (cmd.fix_pos && !below_zero(rd_data))))
      scr_mem[wk[AW-1:0]] <= rd_data;
    sorted_bits <= rd_data;
    end_of_run  <= (rd_idx + 1'b1 == count);
    truncated   <= overflow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; overflow <= 1'b0; idx <= '0; pass <= '0; wk <= '0;
      rd_v <= 1'b0; scr_rd_v <= 1'b0; result_valid <= 1'b0; pfx_total <= '0;
      bk_v <= 1'b0; pf_v <= 1'b0;
    end else begin
      rd_v     <= cmd.rd_req;
      scr_rd_v <= cmd.copy && cmd.idx_inc;
      bk_v     <= rd_v && (cmd.cnt_inc || cmd.scat);
      pf_v     <= cmd.pfx;
      result_valid <= rd_v && cmd.emit;
      if (cmd.clr_run) begin
        count <= '0; overflow <= 1'b0;
      end else if (cmd.load) begin
        if (count < CW'(MAX_ITEMS)) count <= count + 1'b1;
        else overflow <= 1'b1;
      end
      if (cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc) idx <= idx + 1'b1;
      if (cmd.pass_clr) pass <= '0;
      else if (cmd.pass_inc) pass <= pass + 1'b1;
      if (cmd.idx_clr) pfx_total <= '0;
      else if (pf_v) pfx_total <= pfx_total + bkt_rd;
      if (cmd.wk_clr) wk <= '0;
      else if (rd_v && ((cmd.fix_neg && below_zero(rd_data)) ||
                        (cmd.fix_pos && !below_zero(rd_data))))
        wk <= wk + 1'b1;
    end
  end

  assign sts.idx_end_elem = (idx == IW'(count));
  assign sts.idx_end_bkt  = (idx == IW'(NB));
  assign sts.pass_end     = (pass == PW'(PASS_COUNT - 1));
endmodule

// File: rtl/core/rsf64_ctrl.sv
// Sequencer of the radix sorter: load, per-pass clear, count, prefix,
// scatter and copy, then fix-up and emit. Depends on rsf64_pkg.
module rsf64_ctrl import rsf64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       last_item,
  input  rsf64_sts_t sts,
  output rsf64_cmd_t cmd,
  output logic       busy
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CLR   = 11'b00000000010,
    S_CNT   = 11'b00000000100,
    S_PFX   = 11'b00000001000,
    S_SCAT  = 11'b00000010000,
    S_COPY  = 11'b00000100000,
    S_NEG   = 11'b00001000000,
    S_POS   = 11'b00010000000,
    S_FCOPY = 11'b00100000000,
    S_EMIT  = 11'b01000000000,
    S_DRAIN = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   drain, drain_next;   // lets the last read retire before the next sweep
  logic   gap, gap_next;       // bucket update of the previous read in flight

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    drain_next = 1'b0;
    gap_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_item) begin
            cmd.idx_clr = 1'b1; cmd.pass_clr = 1'b1; state_next = S_CLR;
          end
        end
      end
      S_CLR: begin
        if (sts.idx_end_bkt) begin
          cmd.idx_clr = 1'b1; state_next = S_CNT;
        end else begin
          cmd.cnt_clr = 1'b1; cmd.idx_inc = 1'b1;
        end
      end
      S_CNT, S_SCAT, S_NEG, S_POS, S_EMIT: begin
        cmd.cnt_inc = (state == S_CNT);
        cmd.scat    = (state == S_SCAT);
        cmd.fix_neg = (state == S_NEG);
        cmd.fix_pos = (state == S_POS);
        cmd.emit    = (state == S_EMIT);
        if (!gap && !drain && !sts.idx_end_elem) begin
          cmd.rd_req = 1'b1; cmd.idx_inc = 1'b1;
          // count and scatter leave a gap after each read for the bucket update
          gap_next = (state == S_CNT) || (state == S_SCAT);
        end else if (!gap && !drain) begin
          drain_next = 1'b1;
        end else if (drain) begin
          cmd.idx_clr = 1'b1;
          case (state)
            S_CNT:  state_next = S_PFX;
            S_SCAT: state_next = S_COPY;
            S_NEG:  state_next = S_POS;
            S_POS:  state_next = S_FCOPY;
            default: begin
              cmd.clr_run = 1'b1; state_next = S_IDLE;
            end
          endcase
        end
      end
      S_PFX: begin
        if (sts.idx_end_bkt) begin
          cmd.idx_clr = 1'b1; state_next = S_SCAT;
        end else begin
          cmd.pfx = 1'b1; cmd.idx_inc = 1'b1;
        end
      end
      S_COPY, S_FCOPY: begin
        cmd.copy = 1'b1;
        if (!drain && !sts.idx_end_elem) cmd.idx_inc = 1'b1;
        else if (!drain) drain_next = 1'b1;
        else begin
          cmd.idx_clr = 1'b1;
          if (state == S_FCOPY) state_next = S_EMIT;
          else if (sts.pass_end) begin
            cmd.wk_clr = 1'b1; state_next = S_NEG;
          end else begin
            cmd.pass_inc = 1'b1; state_next = S_CLR;
          end
        end
      end
      S_DRAIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; drain <= 1'b0; gap <= 1'b0;
    end else begin
      state <= state_next; drain <= drain_next; gap <= gap_next;
    end
  end
endmodule

// File: rtl/core/radix_sort_float64.sv
// LSD radix sorter for raw 64-bit double patterns, 8 passes of 8-bit digits.
// Load: one item per cycle while busy is low; the item marked last starts the sort.
// Sort: per pass a bucket clear sweep, count, prefix sweep, scatter and copy (count and
// scatter leave a gap after each item read), then fix-up and an emit sweep that gives
// the results on consecutive cycles.
// Synchronous active-high reset empties the store; results cannot be stalled.
module radix_sort_float64 import rsf64_pkg::*; #(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int DIGIT_BITS = DIGIT_BITS_DEF,
  parameter int PASS_COUNT = PASS_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [WORD_W-1:0] value_bits,
  input  logic              last_item,
  output logic              result_valid,
  output logic [WORD_W-1:0] sorted_bits,
  output logic              end_of_run,
  output logic              truncated
);
  rsf64_cmd_t cmd;
  rsf64_sts_t sts;

  // controller: sequences the sweeps
  rsf64_ctrl u_ctrl (
    .clk, .rst, .start, .last_item, .sts, .cmd, .busy
  );

  // datapath: memories, bucket table, counters, result registers
  rsf64_dp #(
    .MAX_ITEMS(MAX_ITEMS), .DIGIT_BITS(DIGIT_BITS), .PASS_COUNT(PASS_COUNT)
  ) u_dp (
    .clk, .rst, .value_bits, .cmd, .sts,
    .result_valid, .sorted_bits, .end_of_run, .truncated
  );
endmodule
